[sv/msnp_pkg.sv]
// ----------------------------------------------------------------------------
// msnp_pkg - shared types and constants of the song-string note parser
// Result and bundle layouts, event kind codes and parse constants.
// ----------------------------------------------------------------------------
package msnp_pkg;

  typedef enum logic [1:0] {
    EV_TONE  = 2'd0,
    EV_DRUM  = 2'd1,
    EV_REST  = 2'd2,
    EV_FLUSH = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e        kind;
    logic signed [8:0]  value;
    logic [7:0]         dur;
  } result_t;

  // up to two results caused by one character, r0 goes out first
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  localparam int OctStep   = 12;
  localparam int OctLimit  = 120;
  localparam int DurMax    = 255;
  localparam int DurWhole  = 32;
  localparam int DurHalf   = 16;
  localparam int DurQuart  = 8;
  localparam int DurEighth = 4;
  localparam int DurSixt   = 2;
  localparam int DurThirty = 1;
  localparam int ToneBaseA = 49;
  localparam int ToneBaseC = 40;
  localparam int RestValue = -1;
  // floor(x / 3) == (x * 171) >> 9 for every 8-bit x
  localparam int ThirdMul  = 171;
  localparam int ThirdShr  = 9;

  localparam logic [7:0] CharSharp = "#";
  localparam logic [7:0] CharFlat  = "!";

endpackage

[sv/music_string_note_parser_unit.sv]
// ----------------------------------------------------------------------------
// music_string_note_parser_unit - song-string note parser
// Turns a stream of song characters into tone, drum, rest and flush beats.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                              | tuser                  | tlast
//  --------+-----+------------------------------------+------------------------+----------
//  s_axis  | in  | [7:0] song_char, [10:8] priority   | [0] start, [1] queued  | song_end
//  m_axis  | out | [8:0] note_value, [16:9] duration  | [1:0] event_kind       | last_of_run
//
//  One character is taken every cycle while the queue has room. A character
//  gives zero, one or two beats; a bundle of two holds the output register
//  for two beats, so sustained rate is one character per cycle when each
//  gives at most one beat and the sink does not stall. An input beat is
//  written into the queue, then loaded into the output register. Reset
//  clears the parse state and the queue at once; no clearing pass. Either
//  side may stall freely: the QueueDepth-entry queue absorbs the difference.
//
module music_string_note_parser_unit
  import msnp_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] song_char, [10:8] song_priority
  input  logic [1:0]  s_axis_tuser,   // [0] song_start, [1] queue_holds_notes
  input  logic        s_axis_tlast,   // song_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [8:0] note_value, [16:9] note_duration
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic    q_full;
  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    head_valid;
  bundle_t head;
  result_t out_res;

  // Decode: classify the character, advance the parse state, build a bundle.
  msnp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s_axis_tvalid),
    .in_ready_o          (s_axis_tready),
    .song_char_i         (s_axis_tdata[7:0]),
    .song_priority_i     (s_axis_tdata[10:8]),
    .song_start_i        (s_axis_tuser[0]),
    .song_end_i          (s_axis_tlast),
    .queue_holds_notes_i (s_axis_tuser[1]),
    .q_full_i            (q_full),
    .push_o              (push),
    .push_data_o         (push_data)
  );

  // Queue: decouple decode from the output side.
  msnp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  // Output: serialise each bundle into beats and hold them for the sink.
  msnp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (out_res),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_res.dur, out_res.value};
  assign m_axis_tuser = out_res.kind;

  // A flush beat carries no note and no duration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_FLUSH |-> m_axis_tdata[16:0] == 17'd0)
    else $error("flush beat with non-zero payload");

  // A rest always carries note value minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_REST |-> m_axis_tdata[8:0] == 9'h1FF)
    else $error("rest beat with wrong note value");

  // A drum always lasts one tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_DRUM |-> m_axis_tdata[16:9] == 8'd1)
    else $error("drum beat with duration other than one");

  // The second beat of a bundle is already queued when the first is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second beat of a bundle missing");

endmodule

[sv/msnp_front.sv]
// ----------------------------------------------------------------------------
// msnp_front - character decode and running parse state
// Accepts one character a cycle while the queue has room, updates octave,
// duration, priority and pending tone, and passes its results as one bundle.
// ----------------------------------------------------------------------------
module msnp_front
  import msnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  song_char_i,
  input  logic [2:0]  song_priority_i,
  input  logic        song_start_i,
  input  logic        song_end_i,
  input  logic        queue_holds_notes_i,
  input  logic        q_full_i,
  output logic        push_o,
  output bundle_t     push_data_o
);

  typedef enum logic [3:0] {
    CC_NONE, CC_OCT_UP, CC_OCT_DN, CC_DOT, CC_THIRD,
    CC_DRUM, CC_DUR, CC_TONE, CC_REST
  } char_class_e;

  logic signed [7:0] oct_q, oct_d;
  logic [7:0]        dur_q, dur_d;
  logic [2:0]        held_q, held_d;
  logic              pend_valid_q, pend_valid_d;
  logic signed [8:0] pend_tone_q, pend_tone_d;
  logic [7:0]        pend_dur_q, pend_dur_d;

  logic              fire;
  logic [7:0]        lc;
  char_class_e       cls;
  logic [7:0]        dur_set;
  logic signed [7:0] oct_eff;
  logic [7:0]        dur_eff;
  logic              pend_eff;
  logic              flush;
  logic signed [8:0] pend_adj;
  logic signed [8:0] oct_sum;
  logic [8:0]        dot_sum;
  logic [15:0]       third_prod;
  logic [8:0]        tone_base;
  logic signed [8:0] tone_num;
  logic              a_valid, b_valid;
  result_t           res_a, res_b;

  assign in_ready_o = ~q_full_i;
  assign fire       = in_valid_i & ~q_full_i;

  always_comb begin
    lc = song_char_i;
    if (song_char_i >= "A" && song_char_i <= "Z") begin
      lc = song_char_i + 8'd32;
    end
    dur_set = 8'(DurThirty);
    cls     = CC_NONE;
    case (lc) inside
      "+":         cls = CC_OCT_UP;
      "-":         cls = CC_OCT_DN;
      ".":         cls = CC_DOT;
      "3":         cls = CC_THIRD;
      ["0":"9"]:   cls = CC_DRUM;
      "w": begin
        cls = CC_DUR; dur_set = 8'(DurWhole);
      end
      "h": begin
        cls = CC_DUR; dur_set = 8'(DurHalf);
      end
      "q": begin
        cls = CC_DUR; dur_set = 8'(DurQuart);
      end
      "i": begin
        cls = CC_DUR; dur_set = 8'(DurEighth);
      end
      "s": begin
        cls = CC_DUR; dur_set = 8'(DurSixt);
      end
      "t": begin
        cls = CC_DUR; dur_set = 8'(DurThirty);
      end
      ["a":"g"]:   cls = CC_TONE;
      "x":         cls = CC_REST;
      default:     cls = CC_NONE;
    endcase
  end

  always_comb begin
    oct_eff  = song_start_i ? 8'sd0 : oct_q;
    dur_eff  = song_start_i ? 8'd1 : dur_q;
    pend_eff = pend_valid_q & ~song_start_i;
    flush    = song_start_i & queue_holds_notes_i & (song_priority_i > held_q);

    held_d = held_q;
    if (song_start_i && (!queue_holds_notes_i || song_priority_i > held_q)) begin
      held_d = song_priority_i;
    end

    pend_adj = pend_tone_q;
    if (song_char_i == CharSharp) begin
      pend_adj = pend_tone_q + 9'sd1;
    end else if (song_char_i == CharFlat) begin
      pend_adj = pend_tone_q - 9'sd1;
    end

    tone_base = (lc <= "b") ? 9'(ToneBaseA) + 9'(lc - "a")
                            : 9'(ToneBaseC) + 9'(lc - "c");
    tone_num  = $signed(tone_base) + 9'(oct_eff);

    dot_sum    = {1'b0, dur_eff} + {2'b00, dur_eff[7:1]};
    third_prod = 16'(dur_eff) * 16'(ThirdMul);

    oct_d = oct_eff;
    dur_d = dur_eff;
    case (cls)
      CC_OCT_UP: begin
        oct_sum = 9'(oct_eff) + 9'(OctStep);
        oct_d   = (oct_sum > 9'(OctLimit)) ? 8'(OctLimit) : oct_sum[7:0];
      end
      CC_OCT_DN: begin
        oct_sum = 9'(oct_eff) - 9'(OctStep);
        oct_d   = (oct_sum < -9'(OctLimit)) ? -8'(OctLimit) : oct_sum[7:0];
      end
      CC_DOT:   dur_d = (dot_sum > 9'(DurMax)) ? 8'(DurMax) : dot_sum[7:0];
      CC_THIRD: dur_d = 8'(third_prod >> ThirdShr);
      CC_DUR:   dur_d = dur_set;
      default:  dur_d = dur_eff;
    endcase
    oct_sum = 9'(oct_eff);
    if (cls == CC_OCT_UP) begin
      oct_sum = 9'(oct_eff) + 9'(OctStep);
    end else if (cls == CC_OCT_DN) begin
      oct_sum = 9'(oct_eff) - 9'(OctStep);
    end

    // first slot: flush request or the resolved pending tone (never both)
    a_valid     = flush | pend_eff;
    res_a.kind  = flush ? EV_FLUSH : EV_TONE;
    res_a.value = flush ? 9'sd0 : pend_adj;
    res_a.dur   = flush ? 8'd0 : pend_dur_q;

    // second slot: what the character itself causes
    b_valid     = 1'b0;
    res_b.kind  = EV_TONE;
    res_b.value = tone_num;
    res_b.dur   = dur_eff;
    case (cls)
      CC_DRUM: begin
        b_valid     = 1'b1;
        res_b.kind  = EV_DRUM;
        res_b.value = 9'($signed({1'b0, lc - "0"}));
        res_b.dur   = 8'd1;
      end
      CC_TONE: b_valid = song_end_i;
      CC_REST: begin
        b_valid     = 1'b1;
        res_b.kind  = EV_REST;
        res_b.value = 9'(RestValue);
      end
      default: b_valid = 1'b0;
    endcase

    pend_valid_d = (cls == CC_TONE) & ~song_end_i;
    pend_tone_d  = tone_num;
    pend_dur_d   = dur_eff;

    push_o            = fire & (a_valid | b_valid);
    push_data_o.two   = a_valid & b_valid;
    push_data_o.r0    = a_valid ? res_a : res_b;
    push_data_o.r1    = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q        <= '0;
      dur_q        <= 8'd1;
      held_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_tone_q  <= '0;
      pend_dur_q   <= '0;
    end else if (fire) begin
      oct_q        <= oct_d;
      dur_q        <= dur_d;
      held_q       <= held_d;
      pend_valid_q <= pend_valid_d;
      if (pend_valid_d) begin
        pend_tone_q <= pend_tone_d;
        pend_dur_q  <= pend_dur_d;
      end
    end
  end

endmodule

[sv/msnp_fifo.sv]
// ----------------------------------------------------------------------------
// msnp_fifo - bundle queue between decode and output
// Holds decoded bundles so that decode and output stall on their own.
// ----------------------------------------------------------------------------
module msnp_fifo
  import msnp_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output bundle_t head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/msnp_back.sv]
// ----------------------------------------------------------------------------
// msnp_back - result serialiser and output register
// Splits each bundle into one or two beats and holds them for the sink.
// ----------------------------------------------------------------------------
module msnp_back
  import msnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  bundle_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_res_o,
  output logic        out_last_o
);

  logic    valid_q, valid_d;
  logic    sel_q, sel_d;
  logic    last_q, last_d;
  result_t res_q, res_d;
  logic    load;

  always_comb begin
    load    = (~valid_q | out_ready_i) & head_valid_i;
    valid_d = valid_q & ~out_ready_i;
    sel_d   = sel_q;
    last_d  = last_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      res_d   = sel_q ? head_i.r1 : head_i.r0;
      last_d  = ~head_i.two | sel_q;
      pop_o   = last_d;
      sel_d   = ~last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule
